@@ src/dpfrc_pkg.sv @@
// shared types and constants for the distinct prime factor range counter
package dpfrc_pkg;

    // default table sizes
    localparam int VALUE_LIMIT_DEF    = 65536;
    localparam int FACTOR_CLASSES_DEF = 11;

    // field widths
    localparam int VALUE_W  = 16;
    localparam int TARGET_W = 4;
    localparam int COUNT_W  = 16;
    localparam int FC_W     = 4;

    // largest factor count the sieve store can hold
    localparam logic [FC_W-1:0] FC_MAX = 4'd15;

    // one query transfer
    typedef struct packed {
        logic [VALUE_W-1:0]  range_low;
        logic [VALUE_W-1:0]  range_high;
        logic [TARGET_W-1:0] factor_target;
    } query_in_t;

    // one result transfer
    typedef struct packed {
        logic [COUNT_W-1:0] match_count;
        logic               query_error;
    } query_out_t;

endpackage

@@ src/distinct_prime_factor_range_count.sv @@
// top level of the distinct prime factor range counter
//
//  channel  | ports                       | transfer
//  ---------+-----------------------------+-------------------------------------
//  query    | start, busy, query          | edge with start high and busy low
//  result   | result_valid, result        | every cycle result_valid is high
//
// after reset busy stays high while the tables are built: the factor store is
// cleared, the sieve scans each value with a read and a check state and marks
// each multiple with a read and a write state, then the prefix sweep reads and
// writes each row. afterwards busy stays low and one query is taken every cycle;
// each result passes the range check stage, the registered prefix store read
// and the select/subtract stage. the receiver cannot stall, so the pipeline
// never holds.
module distinct_prime_factor_range_count
    import dpfrc_pkg::*;
#(
    parameter int VALUE_LIMIT    = VALUE_LIMIT_DEF,
    parameter int FACTOR_CLASSES = FACTOR_CLASSES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  query_in_t  query,
    output logic       result_valid,
    output query_out_t result
);

    localparam int IDX_W = $clog2(VALUE_LIMIT);

    logic                                   tables_ready;
    logic                                   prefix_wr_en;
    logic [IDX_W-1:0]                       prefix_wr_addr;
    logic [FACTOR_CLASSES-1:0][COUNT_W-1:0] prefix_wr_row;

    assign busy = !tables_ready;

    // table build
    dpfrc_init #(
        .VALUE_LIMIT    (VALUE_LIMIT),
        .FACTOR_CLASSES (FACTOR_CLASSES)
    ) u_init (
        .clk            (clk),
        .rst_n          (rst_n),
        .tables_ready   (tables_ready),
        .prefix_wr_en   (prefix_wr_en),
        .prefix_wr_addr (prefix_wr_addr),
        .prefix_wr_row  (prefix_wr_row)
    );

    // query pipeline
    dpfrc_query #(
        .VALUE_LIMIT    (VALUE_LIMIT),
        .FACTOR_CLASSES (FACTOR_CLASSES)
    ) u_query (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (start && tables_ready),
        .in_query       (query),
        .prefix_wr_en   (prefix_wr_en),
        .prefix_wr_addr (prefix_wr_addr),
        .prefix_wr_row  (prefix_wr_row),
        .out_valid      (result_valid),
        .out_result     (result)
    );

endmodule

@@ src/dpfrc_init.sv @@
// table build sequencer: clears and sieves the factor count store, then sweeps prefix rows
module dpfrc_init
    import dpfrc_pkg::*;
#(
    parameter int VALUE_LIMIT    = VALUE_LIMIT_DEF,
    parameter int FACTOR_CLASSES = FACTOR_CLASSES_DEF,
    localparam int IDX_W = $clog2(VALUE_LIMIT),
    localparam int CLS_W = $clog2(FACTOR_CLASSES)
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    output logic                                   tables_ready,
    output logic                                   prefix_wr_en,
    output logic [IDX_W-1:0]                       prefix_wr_addr,
    output logic [FACTOR_CLASSES-1:0][COUNT_W-1:0] prefix_wr_row
);

    typedef logic [FACTOR_CLASSES-1:0][COUNT_W-1:0] row_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_PRE_RD,
        ST_PRE_WR,
        ST_DONE
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(VALUE_LIMIT - 1);
    localparam logic [IDX_W:0]   LIMIT_EXT = (IDX_W+1)'(VALUE_LIMIT);
    localparam logic [FC_W:0]    CLASSES_EXT = (FC_W+1)'(FACTOR_CLASSES);

    // factor count store
    logic [FC_W-1:0] fc_mem [VALUE_LIMIT];
    logic [FC_W-1:0] fc_rd_reg;
    logic            fc_we;
    logic [IDX_W-1:0] fc_waddr;
    logic [FC_W-1:0] fc_wdata;
    logic [IDX_W-1:0] fc_raddr;

    state_t          state_reg, state_next;
    logic [IDX_W-1:0] v_reg, v_next;
    logic [IDX_W-1:0] m_reg, m_next;
    row_t            cnt_reg, cnt_next;
    logic            ready_reg, ready_next;
    logic            wr_en_reg, wr_en_next;
    logic [IDX_W-1:0] wr_addr_reg, wr_addr_next;
    row_t            wr_row_reg, wr_row_next;

    logic [IDX_W:0]  m_sum;
    logic            v_last;

    assign m_sum  = {1'b0, m_reg} + {1'b0, v_reg};
    assign v_last = (v_reg == LAST_IDX);

    // store access, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (fc_we)
        begin
            fc_mem[fc_waddr] <= fc_wdata;
        end
        fc_rd_reg <= fc_mem[fc_raddr];
    end

    // sequencer next state and store controls
    always_comb
    begin
        state_next   = state_reg;
        v_next       = v_reg;
        m_next       = m_reg;
        cnt_next     = cnt_reg;
        ready_next   = ready_reg;
        wr_en_next   = 1'b0;
        wr_addr_next = wr_addr_reg;
        wr_row_next  = wr_row_reg;
        fc_we        = 1'b0;
        fc_waddr     = v_reg;
        fc_wdata     = '0;
        fc_raddr     = v_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                // zero every entry, one a cycle
                fc_we = 1'b1;
                if (v_last)
                begin
                    v_next     = IDX_W'(2);
                    state_next = ST_SCAN_RD;
                end
                else
                begin
                    v_next = v_reg + 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                // unmarked value is prime
                if (fc_rd_reg == '0)
                begin
                    m_next     = v_reg;
                    state_next = ST_MARK_RD;
                end
                else if (v_last)
                begin
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MARK_RD:
            begin
                fc_raddr   = m_reg;
                state_next = ST_MARK_WR;
            end
            ST_MARK_WR:
            begin
                // saturating increment of this multiple
                fc_we    = 1'b1;
                fc_waddr = m_reg;
                fc_wdata = (fc_rd_reg == FC_MAX) ? fc_rd_reg : fc_rd_reg + 1'b1;
                if (m_sum < LIMIT_EXT)
                begin
                    m_next     = m_sum[IDX_W-1:0];
                    state_next = ST_MARK_RD;
                end
                else if (v_last)
                begin
                    v_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_PRE_RD;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PRE_RD:
            begin
                state_next = ST_PRE_WR;
            end
            ST_PRE_WR:
            begin
                // running per-class counts, value zero is never counted
                if ((v_reg != '0) && ({1'b0, fc_rd_reg} < CLASSES_EXT))
                begin
                    cnt_next[fc_rd_reg[CLS_W-1:0]] = cnt_reg[fc_rd_reg[CLS_W-1:0]] + 1'b1;
                end
                wr_en_next   = 1'b1;
                wr_addr_next = v_reg;
                wr_row_next  = cnt_next;
                if (v_last)
                begin
                    ready_next = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    v_next     = v_reg + 1'b1;
                    state_next = ST_PRE_RD;
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            v_reg     <= '0;
            m_reg     <= '0;
            ready_reg <= 1'b0;
            wr_en_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            v_reg     <= v_next;
            m_reg     <= m_next;
            ready_reg <= ready_next;
            wr_en_reg <= wr_en_next;
        end
    end

    // counters and row payload
    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        wr_addr_reg <= wr_addr_next;
        wr_row_reg  <= wr_row_next;
    end

    assign tables_ready   = ready_reg;
    assign prefix_wr_en   = wr_en_reg;
    assign prefix_wr_addr = wr_addr_reg;
    assign prefix_wr_row  = wr_row_reg;

endmodule

@@ src/dpfrc_query.sv @@
// query pipeline: range check, two prefix row reads, class select and subtract
module dpfrc_query
    import dpfrc_pkg::*;
#(
    parameter int VALUE_LIMIT    = VALUE_LIMIT_DEF,
    parameter int FACTOR_CLASSES = FACTOR_CLASSES_DEF,
    localparam int IDX_W = $clog2(VALUE_LIMIT),
    localparam int CLS_W = $clog2(FACTOR_CLASSES)
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  query_in_t                              in_query,
    input  logic                                   prefix_wr_en,
    input  logic [IDX_W-1:0]                       prefix_wr_addr,
    input  logic [FACTOR_CLASSES-1:0][COUNT_W-1:0] prefix_wr_row,
    output logic                                   out_valid,
    output query_out_t                             out_result
);

    typedef logic [FACTOR_CLASSES-1:0][COUNT_W-1:0] row_t;

    localparam logic [TARGET_W:0] CLASSES_EXT = (TARGET_W+1)'(FACTOR_CLASSES);

    // prefix rows, one row per value, all classes side by side
    row_t prefix_mem [VALUE_LIMIT];

    logic             s1_valid_reg;
    logic             s1_err_reg;
    logic             s1_tgt_ok_reg;
    logic [CLS_W-1:0] s1_tgt_reg;
    logic [IDX_W-1:0] s1_addr_hi_reg;
    logic [IDX_W-1:0] s1_addr_lo_reg;

    logic             s2_valid_reg;
    logic             s2_err_reg;
    logic             s2_tgt_ok_reg;
    logic [CLS_W-1:0] s2_tgt_reg;
    row_t             s2_row_hi_reg;
    row_t             s2_row_lo_reg;

    logic             out_valid_reg;
    query_out_t       out_result_reg;

    logic             range_err;
    logic [COUNT_W-1:0] diff;

    // range rejection
    assign range_err = (in_query.range_low == '0)
                    || (in_query.range_low > in_query.range_high)
                    || (32'(in_query.range_high) >= VALUE_LIMIT);

    // valid bits through the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= in_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // stage one: check and form row addresses
    always_ff @(posedge clk)
    begin
        s1_err_reg     <= range_err;
        s1_tgt_ok_reg  <= {1'b0, in_query.factor_target} < CLASSES_EXT;
        s1_tgt_reg     <= in_query.factor_target[CLS_W-1:0];
        s1_addr_hi_reg <= IDX_W'(in_query.range_high);
        s1_addr_lo_reg <= IDX_W'(in_query.range_low - 1'b1);
    end

    // prefix store write port from the build sequencer
    always_ff @(posedge clk)
    begin
        if (prefix_wr_en)
        begin
            prefix_mem[prefix_wr_addr] <= prefix_wr_row;
        end
    end

    // stage two: both row reads
    always_ff @(posedge clk)
    begin
        s2_row_hi_reg <= prefix_mem[s1_addr_hi_reg];
        s2_row_lo_reg <= prefix_mem[s1_addr_lo_reg];
        s2_err_reg    <= s1_err_reg;
        s2_tgt_ok_reg <= s1_tgt_ok_reg;
        s2_tgt_reg    <= s1_tgt_reg;
    end

    // stage three: pick class and subtract, modulo 2^16, zero on error or unknown target
    assign diff = s2_row_hi_reg[s2_tgt_reg] - s2_row_lo_reg[s2_tgt_reg];

    always_ff @(posedge clk)
    begin
        out_result_reg.query_error <= s2_err_reg;
        out_result_reg.match_count <= (s2_err_reg || !s2_tgt_ok_reg) ? '0 : diff;
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

@@ src/dpfrc_checker.sv @@
// port-level checks for the distinct prime factor range counter, bound to the top level
module dpfrc_checker
    import dpfrc_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       result_valid,
    input query_out_t result
);

    // no result while tables are being built
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !result_valid)
        else $error("result strobe while busy");

    // once built, tables stay ready
    assert property (@(posedge clk) disable iff (!rst_n) !busy |=> !busy)
        else $error("busy rose after init");

    // each transfer gives a result once it has passed the pipeline
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 result_valid)
        else $error("missing result for accepted query");

    // every result belongs to a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 3))
        else $error("result without a query");

    // rejected range reports zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.query_error) |-> (result.match_count == '0))
        else $error("nonzero count on error");

endmodule

bind distinct_prime_factor_range_count dpfrc_checker u_checker (.*);
